@@ rtl/core/gpd_pkg.sv @@
// Package for the gamepad poll decoder: word types, controller ID codes,
// and the stored history record shared by the decoder and the top level.
// No dependencies.
package gpd_pkg;

    // Controller ID codes.
    localparam logic [7:0] ID_ANALOG   = 8'h73;
    localparam logic [7:0] ID_PRESSURE = 8'h79;
    localparam logic [7:0] ID_TWIST    = 8'h23;
    localparam logic [7:0] ID_NONE_LO  = 8'h00;
    localparam logic [7:0] ID_NONE_HI  = 8'hFF;

    // Axis value at rest, and the reset value of the press threshold.
    localparam logic [7:0] AXIS_CENTRE      = 8'd128;
    localparam logic [7:0] THRESHOLD_RESET  = 8'd64;
    localparam logic [7:0] PRESSURE_FULL    = 8'hFF;

    // One poll response word.
    typedef struct packed {
        logic [7:0] device_id;
        logic [7:0] buttons_low;
        logic [7:0] buttons_high;
        logic [7:0] extra_a;
        logic [7:0] extra_b;
        logic [7:0] extra_c;
        logic [7:0] extra_d;
    } gpd_in_t;

    // One decoded result word.
    typedef struct packed {
        logic        event_valid;
        logic        link_up;
        logic [15:0] button_map;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
        logic        pressure_valid;
        logic [47:0] pressure_first;
        logic [47:0] pressure_second;
    } gpd_out_t;

    // What was last reported, used for change detection.
    typedef struct packed {
        logic        reported_once;
        logic [15:0] button_map;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
    } gpd_hist_t;

endpackage

@@ rtl/core/gpd_decode.sv @@
// Combinational decode of one poll response into a result word.
// Depends on gpd_pkg for the word types and the ID codes.
module gpd_decode import gpd_pkg::*; (
    input  gpd_in_t    item,
    input  logic [7:0] press_threshold,
    input  gpd_hist_t  hist,
    output gpd_out_t   result
);

    logic        no_device;
    logic        is_twist;
    logic        is_analog;
    logic [15:0] map;
    logic [7:0]  lx;
    logic [7:0]  ly;
    logic [7:0]  rx;
    logic [7:0]  ry;
    logic        changed;

    assign no_device = (item.device_id == ID_NONE_LO) || (item.device_id == ID_NONE_HI);
    assign is_twist  = (item.device_id == ID_TWIST);
    assign is_analog = (item.device_id == ID_ANALOG) || (item.device_id == ID_PRESSURE);

    // Invert the active-low buttons; the twist pad also sets buttons whose analog level exceeds the threshold.
    always_comb begin
        map = ~{item.buttons_high, item.buttons_low};
        if (is_twist) begin
            if (item.extra_b > press_threshold) map[14] = 1'b1;
            if (item.extra_c > press_threshold) map[15] = 1'b1;
            if (item.extra_d > press_threshold) map[10] = 1'b1;
        end
    end

    // Axis selection by controller type.
    always_comb begin
        lx = AXIS_CENTRE;
        ly = AXIS_CENTRE;
        rx = AXIS_CENTRE;
        ry = AXIS_CENTRE;
        if (is_twist) begin
            lx = item.extra_a;
        end else if (is_analog) begin
            rx = item.extra_a;
            ry = item.extra_b;
            lx = item.extra_c;
            ly = item.extra_d;
        end
    end

    assign changed = (map != hist.button_map) || (lx != hist.left_x) || (ly != hist.left_y)
                   || (rx != hist.right_x) || (ry != hist.right_y);

    // Assemble the result; a missing device gives a fixed idle word.
    always_comb begin
        if (no_device) begin
            result                 = '0;
            result.left_x          = AXIS_CENTRE;
            result.left_y          = AXIS_CENTRE;
            result.right_x         = AXIS_CENTRE;
            result.right_y         = AXIS_CENTRE;
        end else begin
            result.event_valid     = !hist.reported_once || is_twist || changed;
            result.link_up         = 1'b1;
            result.button_map      = map;
            result.left_x          = lx;
            result.left_y          = ly;
            result.right_x         = rx;
            result.right_y         = ry;
            result.pressure_valid  = is_twist;
            result.pressure_first  = '0;
            result.pressure_second = '0;
            if (is_twist) begin
                result.pressure_first = {8'h00, 8'h00,
                                         map[7] ? PRESSURE_FULL : 8'h00,
                                         map[6] ? PRESSURE_FULL : 8'h00,
                                         map[5] ? PRESSURE_FULL : 8'h00,
                                         map[4] ? PRESSURE_FULL : 8'h00};
                result.pressure_second = {item.extra_c, item.extra_b,
                                          map[13] ? PRESSURE_FULL : 8'h00,
                                          map[12] ? PRESSURE_FULL : 8'h00,
                                          map[11] ? PRESSURE_FULL : 8'h00,
                                          item.extra_d};
            end
        end
    end

endmodule

@@ rtl/core/gamepad_poll_decoder.sv @@
// Top level of the gamepad poll decoder: input register, decode, result
// register and the reported-value history. Depends on gpd_pkg and gpd_decode.
//
// Usage:
// - s_valid/s_ready/s_data carry one completed poll response word.
// - m_valid/m_ready/m_data carry one decoded result word per response.
// - cfg_valid/cfg_ready/cfg_data write the press threshold; cfg_ready is
//   always high. Write it only while no response is in flight.
// - An accepted word is held in the input register and is decoded into the
//   result register once that register is free. Throughput is one word per
//   cycle while the receiver does not stall, set by the single decode pass
//   between the two registers.
// - History (first-report flag, last reported buttons and axes) is updated
//   as a word with an event moves from the input register into the result register.
// - Reset clears both stage valids, the link flag and the history (axes to
//   128), and sets the threshold to 64.
// - When the receiver stalls, the result word holds, the input register can
//   still take one more word, and s_ready then drops until the result moves.
module gamepad_poll_decoder import gpd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  gpd_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output gpd_out_t   m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    logic       in_valid_reg;
    gpd_in_t    in_data_reg;
    logic       out_valid_reg;
    gpd_out_t   out_data_reg;
    logic [7:0] threshold_reg;
    logic       link_flag_reg;
    gpd_hist_t  hist_reg;
    gpd_hist_t  hist_next;
    gpd_out_t   result;
    logic       out_free;
    logic       advance;

    // Pipeline flow control.
    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || out_free;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

    gpd_decode u_decode (
        .item            (in_data_reg),
        .press_threshold (threshold_reg),
        .hist            (hist_reg),
        .result          (result)
    );

    // History follows the last word that reported an event.
    always_comb begin
        hist_next = hist_reg;
        if (advance && result.event_valid) begin
            hist_next.reported_once = 1'b1;
            hist_next.button_map    = result.button_map;
            hist_next.left_x        = result.left_x;
            hist_next.left_y        = result.left_y;
            hist_next.right_x       = result.right_x;
            hist_next.right_y       = result.right_y;
        end
    end

    // Control state and history.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            threshold_reg          <= THRESHOLD_RESET;
            link_flag_reg          <= 1'b0;
            hist_reg.reported_once <= 1'b0;
            hist_reg.button_map    <= '0;
            hist_reg.left_x        <= AXIS_CENTRE;
            hist_reg.left_y        <= AXIS_CENTRE;
            hist_reg.right_x       <= AXIS_CENTRE;
            hist_reg.right_y       <= AXIS_CENTRE;
        end else begin
            if (s_ready) in_valid_reg <= s_valid;
            if (out_free) out_valid_reg <= in_valid_reg;
            if (cfg_valid) threshold_reg <= cfg_data;
            if (advance) link_flag_reg <= result.link_up;
            hist_reg <= hist_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_data_reg <= s_data;
        if (advance) out_data_reg <= result;
    end

    // A result without a link never reports an event or any buttons.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.link_up |-> !m_data.event_valid && (m_data.button_map == '0))
        else $error("result without link carries an event or buttons");

    // Pressure bytes are only sent with an event.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.pressure_valid |-> m_data.event_valid)
        else $error("pressure word without event");

    // A reported event leaves its buttons in the history.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && result.event_valid |=> hist_reg.reported_once
            && (hist_reg.button_map == m_data.button_map))
        else $error("history does not match the reported event");

    // The link flag tracks the link status of the last decoded word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> link_flag_reg == m_data.link_up)
        else $error("link flag does not follow the last result");

endmodule

@@ tb/tb_gamepad_poll_decoder.sv @@
// Self-checking testbench for gamepad_poll_decoder: directed and random poll
// responses, with random idling on both handshakes, checked against a predictor.
// Depends on gpd_pkg and the decoder RTL.
module tb_gamepad_poll_decoder import gpd_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    gpd_in_t    s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    gpd_out_t   m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = '0;

    // Predictor state: current threshold and the last reported values.
    logic [7:0] press_thr;
    gpd_hist_t  reported;

    gpd_in_t    polls_waiting[$];
    gpd_out_t   decoded_expected[$];
    gpd_in_t    last_poll;
    int         mismatches  = 0;
    int         gap_left    = 0;
    int         stall_left  = 0;
    int         hold_cycles = 0;
    bit         tx_gaps_on  = 1'b1;
    bit         rx_stalls_on = 1'b1;

    gamepad_poll_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Works out the decoded word for one poll response and updates the history.
    function automatic gpd_out_t decode_poll(input gpd_in_t w);
        gpd_out_t   r;
        gpd_hist_t  cur;
        logic [7:0] pr [12];
        logic [15:0] map;
        logic       twist;
        logic       ev;
        r = '0;
        r.left_x  = AXIS_CENTRE;
        r.left_y  = AXIS_CENTRE;
        r.right_x = AXIS_CENTRE;
        r.right_y = AXIS_CENTRE;
        // A missing device gives a fixed word and leaves the history alone.
        if (w.device_id == ID_NONE_LO || w.device_id == ID_NONE_HI) begin
            return r;
        end
        for (int i = 0; i < 12; i++) begin
            pr[i] = 8'h00;
        end
        map = ~{w.buttons_high, w.buttons_low};
        twist = (w.device_id == ID_TWIST);
        if (twist) begin
            r.left_x = w.extra_a;
            if (w.extra_b > press_thr) map[14] = 1'b1;
            if (w.extra_c > press_thr) map[15] = 1'b1;
            if (w.extra_d > press_thr) map[10] = 1'b1;
            if (map[4])  pr[0] = PRESSURE_FULL;
            if (map[5])  pr[1] = PRESSURE_FULL;
            if (map[6])  pr[2] = PRESSURE_FULL;
            if (map[7])  pr[3] = PRESSURE_FULL;
            if (map[11]) pr[7] = PRESSURE_FULL;
            if (map[12]) pr[8] = PRESSURE_FULL;
            if (map[13]) pr[9] = PRESSURE_FULL;
            pr[6]  = w.extra_d;
            pr[10] = w.extra_b;
            pr[11] = w.extra_c;
        end else if (w.device_id == ID_ANALOG || w.device_id == ID_PRESSURE) begin
            r.right_x = w.extra_a;
            r.right_y = w.extra_b;
            r.left_x  = w.extra_c;
            r.left_y  = w.extra_d;
        end
        for (int i = 0; i < 6; i++) begin
            r.pressure_first[8*i +: 8]  = pr[i];
            r.pressure_second[8*i +: 8] = pr[6+i];
        end
        // Report on first poll, on any change, and always for the twist pad.
        cur.reported_once = 1'b1;
        cur.button_map    = map;
        cur.left_x        = r.left_x;
        cur.left_y        = r.left_y;
        cur.right_x       = r.right_x;
        cur.right_y       = r.right_y;
        ev = !reported.reported_once || twist || (cur != reported);
        if (ev) reported = cur;
        r.event_valid    = ev;
        r.link_up        = 1'b1;
        r.button_map     = map;
        r.pressure_valid = twist;
        return r;
    endfunction

    function automatic int tx_gap();
        int k;
        k = $urandom_range(0, 99);
        if (!tx_gaps_on || k < 55) return 0;
        if (k < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Sender: puts queued polls on the input channel and predicts each one
    // at the edge where it is accepted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                decoded_expected.push_back(decode_poll(s_data));
            end
            if (!s_valid || s_ready) begin
                if (polls_waiting.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else begin
                    s_data  <= polls_waiting.pop_front();
                    s_valid <= 1'b1;
                    gap_left = tx_gap();
                end
            end
        end
    end

    task automatic note_mismatch(input string what, input logic [47:0] exp_v,
                                 input logic [47:0] act_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, exp_v, act_v);
        end
    endtask

    task automatic check_word(input gpd_out_t got);
        gpd_out_t want;
        if (decoded_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: result word with nothing expected: %0h", $realtime, got);
            end
            return;
        end
        want = decoded_expected.pop_front();
        if (got.event_valid !== want.event_valid)
            note_mismatch("event_valid", 48'(want.event_valid), 48'(got.event_valid));
        if (got.link_up !== want.link_up)
            note_mismatch("link_up", 48'(want.link_up), 48'(got.link_up));
        if (got.button_map !== want.button_map)
            note_mismatch("button_map", 48'(want.button_map), 48'(got.button_map));
        if (got.left_x !== want.left_x)
            note_mismatch("left_x", 48'(want.left_x), 48'(got.left_x));
        if (got.left_y !== want.left_y)
            note_mismatch("left_y", 48'(want.left_y), 48'(got.left_y));
        if (got.right_x !== want.right_x)
            note_mismatch("right_x", 48'(want.right_x), 48'(got.right_x));
        if (got.right_y !== want.right_y)
            note_mismatch("right_y", 48'(want.right_y), 48'(got.right_y));
        if (got.pressure_valid !== want.pressure_valid)
            note_mismatch("pressure_valid", 48'(want.pressure_valid),
                          48'(got.pressure_valid));
        if (got.pressure_first !== want.pressure_first)
            note_mismatch("pressure_first", want.pressure_first, got.pressure_first);
        if (got.pressure_second !== want.pressure_second)
            note_mismatch("pressure_second", want.pressure_second, got.pressure_second);
    endtask

    // Receiver: checks each accepted result word, then chooses m_ready for
    // the next cycle. A requested hold-off is counted down here.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid === 1'b1 && m_ready) begin
                check_word(m_data);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!rx_stalls_on) begin
                m_ready <= 1'b1;
            end else begin
                case ($urandom_range(0, 99)) inside
                    [0:79]:  m_ready <= 1'b1;
                    [80:95]: begin
                        stall_left = $urandom_range(0, 2);
                        m_ready <= 1'b0;
                    end
                    default: begin
                        stall_left = $urandom_range(8, 30);
                        m_ready <= 1'b0;
                    end
                endcase
            end
        end
    end

    // Queues one poll word; returns once the sender has room for the next.
    task automatic send_poll(input gpd_in_t w);
        polls_waiting.push_back(w);
        last_poll = w;
        while (polls_waiting.size() > 1) @(posedge aclk);
    endtask

    task automatic send_fields(input logic [7:0] id, input logic [7:0] lo,
                               input logic [7:0] hi, input logic [7:0] ea,
                               input logic [7:0] eb, input logic [7:0] ec,
                               input logic [7:0] ed);
        gpd_in_t w;
        w.device_id    = id;
        w.buttons_low  = lo;
        w.buttons_high = hi;
        w.extra_a      = ea;
        w.extra_b      = eb;
        w.extra_c      = ec;
        w.extra_d      = ed;
        send_poll(w);
    endtask

    // Waits until every word is through and checked. The
    // channel is looked at mid-cycle, once the edge updates have settled.
    task automatic wait_decoder_idle();
        @(negedge aclk);
        while (polls_waiting.size() != 0 || s_valid || decoded_expected.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_press_threshold(input logic [7:0] value);
        wait_decoder_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        press_thr = value;
        cfg_valid <= 1'b0;
    endtask

    // First report, no-device polls and history kept across a reconnect.
    task automatic test_link_and_first_report();
        send_fields(8'h41, 8'hFF, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78);
        send_fields(8'h41, 8'hFF, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h78);
        send_fields(ID_NONE_LO, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_fields(ID_NONE_HI, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_fields(8'h41, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
        send_fields(8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    endtask

    // Both analog IDs with axis extremes, a repeat and a single axis change.
    task automatic test_analog_axes();
        send_fields(ID_ANALOG, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00);
        send_fields(ID_ANALOG, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_fields(ID_PRESSURE, 8'h5A, 8'hA5, 8'h01, 8'h02, 8'h03, 8'h04);
        send_fields(ID_PRESSURE, 8'h5A, 8'hA5, 8'h01, 8'h02, 8'h03, 8'h04);
        send_fields(ID_PRESSURE, 8'h5A, 8'hA5, 8'h01, 8'h02, 8'h03, 8'h05);
        send_fields(8'h41, 8'h5A, 8'hA5, 8'h01, 8'h02, 8'h03, 8'h05);
    endtask

    // Twist pad at the default threshold, just at and just above it.
    task automatic test_twist_pad();
        send_fields(ID_TWIST, 8'hFF, 8'hFF, 8'h80, 8'd64, 8'd64, 8'd64);
        send_fields(ID_TWIST, 8'hFF, 8'hFF, 8'h80, 8'd64, 8'd64, 8'd64);
        send_fields(ID_TWIST, 8'hFF, 8'hFF, 8'h00, 8'd65, 8'd65, 8'd65);
        send_fields(ID_TWIST, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00);
        send_fields(ID_TWIST, 8'h0F, 8'hF0, 8'h7F, 8'hFF, 8'hFF, 8'hFF);
    endtask

    // Threshold at both ends of its range.
    task automatic test_threshold_extremes();
        set_press_threshold(8'd0);
        send_fields(ID_TWIST, 8'hFF, 8'hFF, 8'h10, 8'd0, 8'd1, 8'd0);
        set_press_threshold(8'd255);
        send_fields(ID_TWIST, 8'hFF, 8'hFF, 8'h10, 8'd255, 8'd255, 8'd254);
        set_press_threshold(THRESHOLD_RESET);
    endtask

    // The receiver holds off while the sender keeps offering words, so the
    // decoder fills up and drops s_ready.
    task automatic test_backpressure();
        wait_decoder_idle();
        tx_gaps_on  = 1'b0;
        hold_cycles = 60;
        for (int i = 0; i < 12; i++) begin
            send_fields(i[0] ? ID_ANALOG : ID_TWIST, 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
        wait_decoder_idle();
        tx_gaps_on = 1'b1;
    endtask

    // Mostly valid IDs with random content; repeats exercise the no-event path,
    // one-bit changes give the smallest event, and twist levels often sit around the threshold.
    function automatic gpd_in_t random_poll();
        gpd_in_t w;
        int k;
        k = $urandom_range(0, 99);
        if (k < 25) return last_poll;
        w = last_poll;
        if (k < 32) begin
            if ($urandom_range(0, 1)) w.buttons_low[$urandom_range(0, 7)] ^= 1'b1;
            else w.buttons_high[$urandom_range(0, 7)] ^= 1'b1;
            return w;
        end
        w.buttons_low  = 8'($urandom);
        w.buttons_high = 8'($urandom);
        w.extra_a      = 8'($urandom);
        w.extra_b      = 8'($urandom);
        w.extra_c      = 8'($urandom);
        w.extra_d      = 8'($urandom);
        case ($urandom_range(0, 99)) inside
            [0:29]:  w.device_id = ID_TWIST;
            [30:49]: w.device_id = ID_ANALOG;
            [50:64]: w.device_id = ID_PRESSURE;
            [65:69]: w.device_id = ID_NONE_LO;
            [70:74]: w.device_id = ID_NONE_HI;
            default: w.device_id = 8'($urandom);
        endcase
        if (w.device_id == ID_TWIST && $urandom_range(0, 1)) begin
            w.extra_b = press_thr + 8'($urandom_range(0, 2)) - 8'd1;
            w.extra_c = press_thr + 8'($urandom_range(0, 2)) - 8'd1;
            w.extra_d = press_thr + 8'($urandom_range(0, 2)) - 8'd1;
        end
        if ($urandom_range(0, 3) == 0) begin
            w.buttons_low  = 8'hFF;
            w.buttons_high = 8'hFF;
        end
        return w;
    endfunction

    // Ten phases with a new threshold each and varying idle patterns.
    task automatic test_random_traffic();
        logic [7:0] thr_plan [10];
        thr_plan = '{8'd0, 8'd200, 8'd255, 8'($urandom), 8'd64,
                     8'd1, 8'd254, 8'($urandom), 8'd128, 8'($urandom)};
        for (int p = 0; p < 10; p++) begin
            set_press_threshold(thr_plan[p]);
            tx_gaps_on   = (p % 4 != 1);
            rx_stalls_on = (p % 4 != 2);
            for (int i = 0; i < 190; i++) begin
                send_poll(random_poll());
            end
        end
    endtask

    initial begin
        press_thr = THRESHOLD_RESET;
        reported.reported_once = 1'b0;
        reported.button_map    = '0;
        reported.left_x        = AXIS_CENTRE;
        reported.left_y        = AXIS_CENTRE;
        reported.right_x       = AXIS_CENTRE;
        reported.right_y       = AXIS_CENTRE;
        last_poll = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_link_and_first_report();
        test_analog_axes();
        test_twist_pad();
        test_threshold_extremes();
        test_backpressure();
        test_random_traffic();

        wait_decoder_idle();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_gamepad_poll_decoder OK");
        end else begin
            $display("tb_gamepad_poll_decoder NOT OK");
        end
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("tb_gamepad_poll_decoder NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/gpd_pkg.sv
rtl/core/gpd_decode.sv
rtl/core/gamepad_poll_decoder.sv
tb/tb_gamepad_poll_decoder.sv
